// ----- rtl/core/dns_pkg.sv -----
// Shared types and widths for the depth normal shading block.
`default_nettype none

package dns_pkg;

   // Vertex component, neighbour difference and cross product widths
   localparam int VTX_W = 16;
   localparam int DIFF_W = VTX_W + 1;
   localparam int CROSS_W = 2 * DIFF_W;
   localparam int UNIT_W = 16;
   localparam int POS_W = 10;

   typedef struct packed {
      logic signed [VTX_W-1:0] x;
      logic signed [VTX_W-1:0] y;
      logic [VTX_W-1:0]        z;
   } vertex_type;

   // One classified request: four diagonal differences (UL, UR, DR, DL) minus centre
   typedef struct packed {
      logic                                 zero_depth;
      logic [3:0][2:0][DIFF_W-1:0]          diff;
      logic [POS_W-1:0]                     column;
      logic [POS_W-1:0]                     row;
   } item_type;

   // Neighbour minus centre, one component at a time
   function automatic logic [2:0][DIFF_W-1:0] vertex_sub(input vertex_type n,
                                                         input vertex_type c);
      logic [2:0][DIFF_W-1:0] d;
      d[0] = DIFF_W'(n.x) - DIFF_W'(c.x);
      d[1] = DIFF_W'(n.y) - DIFF_W'(c.y);
      d[2] = {1'b0, n.z} - {1'b0, c.z};
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dns_queue.sv -----
// Two-entry queue between the front and back of the shading block.
`default_nettype none

module dns_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dns_pkg::item_type push_item,
   input  wire logic              pop,
   output logic                   full,
   output logic                   empty,
   output dns_pkg::item_type      head
);
   import dns_pkg::*;

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == QUEUE_DEPTH);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/dns_front.sv -----
// Front end: line buffer, 3x3 window, raster counters and request classification.
`default_nettype none

module dns_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [10:0]         frame_width,
   input  wire logic [10:0]         frame_height,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire dns_pkg::vertex_type vertex,
   input  wire logic                queue_full,
   output logic                     push,
   output dns_pkg::item_type        item
);
   import dns_pkg::*;

   localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
   localparam logic [EW-1:0] W_MIN = EW'(3);
   localparam logic [EW-1:0] W_MAX = EW'(MAX_WIDTH);
   localparam logic [10:0] H_MIN = 11'd3;
   localparam logic [10:0] H_MAX = 11'd1024;
   localparam int LW = 2 * $bits(vertex_type);

   localparam logic F_TAKE   = 1'b0;
   localparam logic F_UPDATE = 1'b1;

   logic             state_ff;
   logic [AW-1:0]    col_ff;
   logic [POS_W-1:0] row_ff;
   vertex_type       nv_ff;
   logic [LW-1:0]    rd_ff;
   vertex_type       win1_ff [3];
   vertex_type       win2_ff [3];
   logic [LW-1:0]    line_mem [MAX_WIDTH];

   vertex_type    rd_upper;
   vertex_type    rd_middle;
   logic          take;
   logic [EW-1:0] w_raw;
   logic [EW-1:0] w_eff;
   logic [10:0]   h_eff;
   logic          col_wrap;
   logic          row_wrap;

   assign req_ready = (state_ff == F_TAKE) && !queue_full;
   assign take      = req_valid && req_ready;
   assign rd_upper  = rd_ff[LW-1 -: $bits(vertex_type)];
   assign rd_middle = rd_ff[$bits(vertex_type)-1:0];

   // Clamped frame size and end-of-row / end-of-frame tests
   always_comb begin
      w_raw = EW'(frame_width);
      if (w_raw < W_MIN) w_eff = W_MIN;
      else if (w_raw > W_MAX) w_eff = W_MAX;
      else w_eff = w_raw;
      if (frame_height < H_MIN) h_eff = H_MIN;
      else if (frame_height > H_MAX) h_eff = H_MAX;
      else h_eff = frame_height;
      col_wrap = (EW'(col_ff) + EW'(1)) >= w_eff;
      row_wrap = (11'(row_ff) + 11'd1) >= h_eff;
   end

   // Line buffer: each entry holds the upper and middle row vertex of one column
   always_ff @(posedge clock) begin
      if (take) begin
         rd_ff <= line_mem[col_ff];
      end
      if (state_ff == F_UPDATE) begin
         line_mem[col_ff] <= {rd_middle, nv_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (take) nv_ff <= vertex;
   end

   // Sequencer, counters and window
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_TAKE;
         col_ff   <= '0;
         row_ff   <= '0;
         for (int i = 0; i < 3; i++) begin
            win1_ff[i] <= '0;
            win2_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            F_TAKE: begin
               if (take) state_ff <= F_UPDATE;
            end
            F_UPDATE: begin
               state_ff <= F_TAKE;
               for (int i = 0; i < 3; i++) win1_ff[i] <= win2_ff[i];
               win2_ff[0] <= rd_upper;
               win2_ff[1] <= rd_middle;
               win2_ff[2] <= nv_ff;
               if (col_wrap) begin
                  col_ff <= '0;
                  row_ff <= row_wrap ? '0 : row_ff + POS_W'(1);
               end else begin
                  col_ff <= col_ff + AW'(1);
               end
            end
            default: state_ff <= F_TAKE;
         endcase
      end
   end

   // Interior pixels go to the back end; centre is the previous column's middle row
   always_comb begin
      push = (state_ff == F_UPDATE) && (col_ff >= AW'(2)) && (row_ff >= POS_W'(2));
      item.zero_depth = (win2_ff[1].z == '0);
      item.diff[0]    = vertex_sub(win1_ff[0], win2_ff[1]);
      item.diff[1]    = vertex_sub(rd_upper, win2_ff[1]);
      item.diff[2]    = vertex_sub(nv_ff, win2_ff[1]);
      item.diff[3]    = vertex_sub(win1_ff[2], win2_ff[1]);
      item.column     = POS_W'(col_ff - AW'(1));
      item.row        = row_ff - POS_W'(1);
   end

endmodule

`default_nettype wire

// ----- rtl/core/dns_norm.sv -----
// Iterative vector normalizer: shift scaling, sum of squares, bitwise root, Q1.15 divide.
`default_nettype none

module dns_norm (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic [2:0][dns_pkg::CROSS_W-1:0]         vec,
   output logic [2:0][dns_pkg::UNIT_W-1:0]               unit_vec,
   output logic                                          done
);
   import dns_pkg::*;

   localparam int MW = CROSS_W;
   localparam int SW = 63;
   localparam int LEN_W = 32;
   localparam logic [MW-1:0] TOP_BIT = MW'(1) << 30;
   localparam logic [MW-1:0] LOW_BIT = MW'(1) << 29;
   localparam logic [MW-1:0] FAR_BIT = MW'(1) << 21;
   localparam logic [UNIT_W-1:0] Q_MAX = UNIT_W'(32767);

   localparam logic [2:0] N_IDLE   = 3'd0;
   localparam logic [2:0] N_SCALE  = 3'd1;
   localparam logic [2:0] N_SQUARE = 3'd2;
   localparam logic [2:0] N_ROOT   = 3'd3;
   localparam logic [2:0] N_DIVIDE = 3'd4;
   localparam logic [2:0] N_FINISH = 3'd5;

   logic [2:0]        state_ff;
   logic [2:0]        neg_ff;
   logic [MW-1:0]     mag_ff [3];
   logic [SW-1:0]     s_ff;
   logic [SW-1:0]     r_ff;
   logic [4:0]        it_ff;
   logic [1:0]        sel_ff;
   logic [LEN_W-1:0]  rem_ff [3];
   logic [UNIT_W-1:0] q_ff [3];

   logic [MW-1:0]    mx;
   logic [59:0]      square;
   logic [SW-1:0]    bit_w;
   logic [SW-1:0]    trial;
   logic [LEN_W-1:0] len;

   // Largest magnitude, one square and one root trial per cycle
   always_comb begin
      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];
      square = 60'(mag_ff[sel_ff][29:0]) * 60'(mag_ff[sel_ff][29:0]);
      bit_w  = SW'(1) << {it_ff, 1'b0};
      trial  = r_ff + bit_w;
      len    = r_ff[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done     <= 1'b0;
      end else begin
         // Done pulses on a zero vector or after the final sign fix
         done <= ((state_ff == N_SCALE) && (mx == '0)) || (state_ff == N_FINISH);
         unique case (state_ff)
            N_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= vec[i][MW-1];
                     mag_ff[i] <= vec[i][MW-1] ? (~vec[i] + MW'(1)) : vec[i];
                  end
                  state_ff <= N_SCALE;
               end
            end
            N_SCALE: begin
               // Bring the largest magnitude into [2^29, 2^30)
               if (mx == '0) begin
                  for (int i = 0; i < 3; i++) unit_vec[i] <= '0;
                  state_ff <= N_IDLE;
               end else if (mx >= TOP_BIT) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
               end else if (mx < FAR_BIT) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 8;
               end else if (mx < LOW_BIT) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
               end else begin
                  s_ff     <= '0;
                  sel_ff   <= 2'd0;
                  state_ff <= N_SQUARE;
               end
            end
            N_SQUARE: begin
               s_ff <= s_ff + SW'(square);
               if (sel_ff == 2'd2) begin
                  r_ff     <= '0;
                  it_ff    <= 5'd31;
                  state_ff <= N_ROOT;
               end else begin
                  sel_ff <= sel_ff + 2'd1;
               end
            end
            N_ROOT: begin
               if (s_ff >= trial) begin
                  s_ff <= s_ff - trial;
                  r_ff <= (r_ff >> 1) + bit_w;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               if (it_ff == 5'd0) begin
                  for (int i = 0; i < 3; i++) begin
                     rem_ff[i] <= LEN_W'(mag_ff[i][29:0]);
                     q_ff[i]   <= '0;
                  end
                  it_ff    <= 5'd15;
                  state_ff <= N_DIVIDE;
               end else begin
                  it_ff <= it_ff - 5'd1;
               end
            end
            N_DIVIDE: begin
               // Three restoring dividers, one quotient bit each per cycle
               for (int i = 0; i < 3; i++) begin
                  if (rem_ff[i] >= len) begin
                     rem_ff[i] <= (rem_ff[i] - len) << 1;
                     q_ff[i]   <= {q_ff[i][UNIT_W-2:0], 1'b1};
                  end else begin
                     rem_ff[i] <= rem_ff[i] << 1;
                     q_ff[i]   <= {q_ff[i][UNIT_W-2:0], 1'b0};
                  end
               end
               it_ff <= it_ff - 5'd1;
               if (it_ff == 5'd0) state_ff <= N_FINISH;
            end
            N_FINISH: begin
               for (int i = 0; i < 3; i++) begin
                  if (neg_ff[i]) begin
                     unit_vec[i] <= (q_ff[i] > Q_MAX) ? (~Q_MAX + UNIT_W'(1))
                                                      : (~q_ff[i] + UNIT_W'(1));
                  end else begin
                     unit_vec[i] <= (q_ff[i] > Q_MAX) ? Q_MAX : q_ff[i];
                  end
               end
               state_ff <= N_IDLE;
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/dns_back.sv -----
// Back end: cross products, normal averaging, light dot product and result register.
`default_nettype none

module dns_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          queue_empty,
   input  wire dns_pkg::item_type             head,
   output logic                               pop,
   input  wire logic [15:0]                   light_x,
   input  wire logic [15:0]                   light_y,
   input  wire logic [15:0]                   light_z,
   input  wire logic                          light_changed,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_shade,
   output logic [dns_pkg::POS_W-1:0]          rsp_centre_column,
   output logic [dns_pkg::POS_W-1:0]          rsp_centre_row
);
   import dns_pkg::*;

   localparam int SUM_W = UNIT_W + 2;
   localparam int DOT_W = 34;

   localparam logic [3:0] B_IDLE   = 4'd0;
   localparam logic [3:0] B_CROSS  = 4'd1;
   localparam logic [3:0] B_NCROSS = 4'd2;
   localparam logic [3:0] B_NSUM   = 4'd3;
   localparam logic [3:0] B_NLIGHT = 4'd4;
   localparam logic [3:0] B_DOT    = 4'd5;
   localparam logic [3:0] B_SCALE  = 4'd6;
   localparam logic [3:0] B_EMIT   = 4'd7;

   // Operand pick for the six products of a cross product: {a index, b index}
   function automatic logic [3:0] cross_pick(input logic [2:0] step);
      case (step)
         3'd0:    return {2'd1, 2'd2};
         3'd1:    return {2'd2, 2'd1};
         3'd2:    return {2'd2, 2'd0};
         3'd3:    return {2'd0, 2'd2};
         3'd4:    return {2'd0, 2'd1};
         default: return {2'd1, 2'd0};
      endcase
   endfunction

   logic [3:0]                   state_ff;
   logic [3:0][2:0][DIFF_W-1:0]  diff_ff;
   logic [POS_W-1:0]             col_ff;
   logic [POS_W-1:0]             row_ff;
   logic [1:0]                   k_ff;
   logic [2:0]                   step_ff;
   logic signed [CROSS_W-1:0]    cp_ff [3];
   logic signed [SUM_W-1:0]      sum_ff [3];
   logic signed [UNIT_W-1:0]     nrm_ff [3];
   logic signed [UNIT_W-1:0]     lu_ff [3];
   logic                         light_ok_ff;
   logic signed [DOT_W-1:0]      dot_ff;
   logic [7:0]                   shade_ff;
   logic                         start_ff;

   logic                         start_in;
   logic [3:0]                   pick;
   logic signed [DIFF_W-1:0]     a_op;
   logic signed [DIFF_W-1:0]     b_op;
   logic signed [CROSS_W-1:0]    prod;
   logic signed [DOT_W-1:0]      dot_term;
   logic [DOT_W-1:0]             dot_mag;
   logic [DOT_W+7:0]             scaled;
   logic [11:0]                  shade_wide;
   logic [2:0][CROSS_W-1:0]      norm_vec;
   logic [2:0][UNIT_W-1:0]       norm_unit;
   logic                         norm_done;
   logic                         emit_ok;

   dns_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .vec      (norm_vec),
      .unit_vec (norm_unit),
      .done     (norm_done)
   );

   // Multiplier operands and result scaling
   always_comb begin
      pick     = cross_pick(step_ff);
      a_op     = $signed(diff_ff[k_ff][pick[3:2]]);
      b_op     = $signed(diff_ff[k_ff + 2'd1][pick[1:0]]);
      prod     = CROSS_W'(a_op) * CROSS_W'(b_op);
      dot_term = DOT_W'(nrm_ff[step_ff[1:0]]) * DOT_W'(lu_ff[step_ff[1:0]]);
      dot_mag  = dot_ff[DOT_W-1] ? DOT_W'(-dot_ff) : DOT_W'(dot_ff);
      scaled   = {dot_mag, 8'd0} - {8'd0, dot_mag};
      shade_wide = scaled[DOT_W+7:30];
      emit_ok  = !rsp_valid || rsp_ready;
      pop      = (state_ff == B_IDLE) && !queue_empty;
      // Normalizer start: after a cross product, after the last one, and for the light
      start_in = ((state_ff == B_CROSS) && (step_ff == 3'd5)) ||
                 ((state_ff == B_NCROSS) && norm_done && (k_ff == 2'd3)) ||
                 ((state_ff == B_NSUM) && norm_done && !light_ok_ff);
   end

   // Normalizer operand select
   always_comb begin
      unique case (state_ff)
         B_NSUM: begin
            for (int i = 0; i < 3; i++) norm_vec[i] = CROSS_W'(sum_ff[i]);
         end
         B_NLIGHT: begin
            norm_vec[0] = CROSS_W'($signed(light_x));
            norm_vec[1] = CROSS_W'($signed(light_y));
            norm_vec[2] = CROSS_W'($signed(light_z));
         end
         default: begin
            for (int i = 0; i < 3; i++) norm_vec[i] = cp_ff[i];
         end
      endcase
   end

   // Per-request sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         light_ok_ff <= 1'b0;
         start_ff    <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         start_ff <= start_in;
         // A response taken while no new one is loaded
         if (rsp_valid && rsp_ready && (state_ff != B_EMIT)) rsp_valid <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (!queue_empty) begin
                  diff_ff <= head.diff;
                  col_ff  <= head.column;
                  row_ff  <= head.row;
                  k_ff    <= 2'd0;
                  step_ff <= 3'd0;
                  for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
                  if (head.zero_depth) begin
                     shade_ff <= 8'd0;
                     state_ff <= B_EMIT;
                  end else begin
                     state_ff <= B_CROSS;
                  end
               end
            end
            B_CROSS: begin
               if (step_ff[0]) cp_ff[step_ff[2:1]] <= cp_ff[step_ff[2:1]] - prod;
               else cp_ff[step_ff[2:1]] <= prod;
               if (step_ff == 3'd5) begin
                  state_ff <= B_NCROSS;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            B_NCROSS: begin
               if (norm_done) begin
                  for (int i = 0; i < 3; i++) begin
                     sum_ff[i] <= sum_ff[i] + SUM_W'($signed(norm_unit[i]));
                  end
                  step_ff <= 3'd0;
                  if (k_ff == 2'd3) begin
                     state_ff <= B_NSUM;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= B_CROSS;
                  end
               end
            end
            B_NSUM: begin
               if (norm_done) begin
                  for (int i = 0; i < 3; i++) nrm_ff[i] <= $signed(norm_unit[i]);
                  if (light_ok_ff) begin
                     state_ff <= B_DOT;
                  end else begin
                     state_ff <= B_NLIGHT;
                  end
               end
            end
            B_NLIGHT: begin
               if (norm_done) begin
                  for (int i = 0; i < 3; i++) lu_ff[i] <= $signed(norm_unit[i]);
                  state_ff <= B_DOT;
               end
            end
            B_DOT: begin
               dot_ff <= (step_ff == 3'd0) ? dot_term : dot_ff + dot_term;
               if (step_ff == 3'd2) state_ff <= B_SCALE;
               else step_ff <= step_ff + 3'd1;
            end
            B_SCALE: begin
               shade_ff <= (shade_wide > 12'd255) ? 8'hFF : shade_wide[7:0];
               state_ff <= B_EMIT;
            end
            B_EMIT: begin
               if (emit_ok) begin
                  rsp_valid         <= 1'b1;
                  rsp_shade         <= shade_ff;
                  rsp_centre_column <= col_ff;
                  rsp_centre_row    <= row_ff;
                  state_ff          <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
         // Cached unit light: valid once computed, dropped on a light register write
         if (light_changed) light_ok_ff <= 1'b0;
         else if ((state_ff == B_NLIGHT) && norm_done) light_ok_ff <= 1'b1;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/depth_normal_shading.sv -----
// Top level of the depth normal shading block: registers, front, queue and back.
`default_nettype none

// Lambert shading of a raster stream of camera-space vertices. Each request is
// one vertex (mm) in raster order; each interior pixel (not in the first or last
// row or column) yields one response once the request one column and one row
// later arrives, carrying its column, row and an 8-bit grey level
// floor(|cos(normal, light)| * 255), or 0 when its depth is 0. Border pixels give
// no response. The front takes a request (line buffer read, then update) into a
// two-entry queue, and takes none during the update or while the queue is full.
// The back does no arithmetic for a zero-depth pixel; one with depth gets four cross
// products, each followed by a pass through one shared normalizer (scaling, 32-step
// square root, 16-step divide), then one pass for the summed normal; a light pass
// follows only for the first such pixel after reset or a light register write.
// Registers are written over an APB-style port at byte address 4*i; write them
// only while the block is idle.

module depth_normal_shading #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_vertex_x,
   input  wire logic signed [15:0] req_vertex_y,
   input  wire logic [15:0]        req_vertex_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_shade,
   output logic [9:0]              rsp_centre_column,
   output logic [9:0]              rsp_centre_row,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import dns_pkg::*;

   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_LIGHT_X      = 3'd2;
   localparam logic [2:0] REG_LIGHT_Y      = 3'd3;
   localparam logic [2:0] REG_LIGHT_Z      = 3'd4;

   logic [10:0] frame_width_ff;
   logic [10:0] frame_height_ff;
   logic [15:0] light_x_ff;
   logic [15:0] light_y_ff;
   logic [15:0] light_z_ff;

   logic       csr_write;
   logic [2:0] csr_index;
   logic       light_changed;
   vertex_type req_vertex;
   logic       front_push;
   item_type   front_item;
   logic       queue_full;
   logic       queue_empty;
   logic       queue_pop;
   item_type   queue_head;

   assign csr_pready    = 1'b1;
   assign csr_index     = csr_paddr[4:2];
   assign csr_write     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign light_changed = csr_write && ((csr_index == REG_LIGHT_X) ||
                          (csr_index == REG_LIGHT_Y) || (csr_index == REG_LIGHT_Z));

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 11'd480;
         light_x_ff      <= 16'd0;
         light_y_ff      <= 16'd0;
         light_z_ff      <= 16'd32767;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[10:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[10:0];
            REG_LIGHT_X:      light_x_ff      <= csr_pwdata[15:0];
            REG_LIGHT_Y:      light_y_ff      <= csr_pwdata[15:0];
            REG_LIGHT_Z:      light_z_ff      <= csr_pwdata[15:0];
            default:          ;
         endcase
      end
   end

   // Register read back
   always_comb begin
      unique case (csr_index)
         REG_FRAME_WIDTH:  csr_prdata = 32'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = 32'(frame_height_ff);
         REG_LIGHT_X:      csr_prdata = 32'(light_x_ff);
         REG_LIGHT_Y:      csr_prdata = 32'(light_y_ff);
         REG_LIGHT_Z:      csr_prdata = 32'(light_z_ff);
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      req_vertex.x = req_vertex_x;
      req_vertex.y = req_vertex_y;
      req_vertex.z = req_vertex_z;
   end

   dns_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .vertex       (req_vertex),
      .queue_full   (queue_full),
      .push         (front_push),
      .item         (front_item)
   );

   dns_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .pop       (queue_pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   dns_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .head              (queue_head),
      .pop               (queue_pop),
      .light_x           (light_x_ff),
      .light_y           (light_y_ff),
      .light_z           (light_z_ff),
      .light_changed     (light_changed),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_shade         (rsp_shade),
      .rsp_centre_column (rsp_centre_column),
      .rsp_centre_row    (rsp_centre_row)
   );

`ifndef SYNTHESIS
   // The front only accepts when it has room to push
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !queue_full)
      else $error("request pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_empty)
      else $error("pop from an empty queue");

   // No request is accepted while the line buffer is updated after an accepted one
   a_update_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted during line buffer update");

   // Responses never name the first row as centre row
   a_interior_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_centre_row != 10'd0))
      else $error("response for a border row");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_depth_normal_shading.sv -----
// Testbench for depth_normal_shading: predicts the shading of a vertex stream and checks every result.
`timescale 1ns / 1ps

module tb_depth_normal_shading;
   import dns_pkg::*;

   localparam int LINE_MAX = 1024;
   localparam int WIDE_COLUMNS = 40;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 400;

   // Register byte addresses
   localparam logic [4:0] REG_WIDTH   = 5'd0;
   localparam logic [4:0] REG_HEIGHT  = 5'd4;
   localparam logic [4:0] REG_LIGHT_X = 5'd8;
   localparam logic [4:0] REG_LIGHT_Y = 5'd12;
   localparam logic [4:0] REG_LIGHT_Z = 5'd16;

   typedef struct {
      longint c[3];
   } trio_t;

   typedef struct {
      longint x;
      longint y;
      longint z;
   } point_t;

   typedef struct {
      logic [7:0] shade;
      logic [9:0] column;
      logic [9:0] row;
   } shade_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic signed [15:0] req_vertex_x = '0;
   logic signed [15:0] req_vertex_y = '0;
   logic [15:0] req_vertex_z = '0;
   logic rsp_ready = 1'b0;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire req_ready;
   wire rsp_valid;
   wire [7:0] rsp_shade;
   wire [9:0] rsp_centre_column;
   wire [9:0] rsp_centre_row;
   wire [31:0] csr_prdata;
   wire csr_pready;

   depth_normal_shading uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y), .req_vertex_z(req_vertex_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_shade(rsp_shade),
      .rsp_centre_column(rsp_centre_column), .rsp_centre_row(rsp_centre_row),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow registers and pipeline state of the shader
   logic [10:0] frame_width_q = 11'd640;
   logic [10:0] frame_height_q = 11'd480;
   logic signed [15:0] light_q [3] = '{16'sd0, 16'sd0, 16'sd32767};
   point_t upper_buf [LINE_MAX];
   point_t middle_buf [LINE_MAX];
   point_t win [3][3];
   int unsigned col_cnt = 0;
   int unsigned row_cnt = 0;

   shade_t shades_due [$];
   int errors = 0;
   int cycles = 0;
   bit gaps_on = 1'b1;
   bit ready_random = 1'b0;
   bit hold_req = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   // Integer square root, one bit per step
   function automatic longint unsigned sqrt_floor(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Scale to Q1.15 unit length; zero stays zero
   function automatic trio_t to_unit(trio_t v);
      longint unsigned m [3];
      longint unsigned mx, s, len, q;
      bit neg [3];
      trio_t o;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v.c[i] < 0;
         m[i] = neg[i] ? -v.c[i] : v.c[i];
         if (m[i] > mx) mx = m[i];
         o.c[i] = 0;
      end
      if (mx == 0) return o;
      while (mx >= (64'd1 << 30)) begin
         mx = mx >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (mx < (64'd1 << 29)) begin
         mx = mx << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = sqrt_floor(s);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 64'd32768) / len;
         if (q > 32767) q = 32767;
         o.c[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return o;
   endfunction

   function automatic trio_t offset_of(point_t n, point_t c);
      trio_t d;
      d.c[0] = n.x - c.x;
      d.c[1] = n.y - c.y;
      d.c[2] = n.z - c.z;
      return d;
   endfunction

   // Lambert shade of the current 3x3 window
   function automatic logic [7:0] window_shade();
      trio_t d [4];
      trio_t a, b, cp, u, sum, nrm, lt, lu;
      longint dotv;
      longint unsigned mag, sh;
      if (win[1][1].z == 0) return 8'd0;
      d[0] = offset_of(win[0][0], win[1][1]);
      d[1] = offset_of(win[0][2], win[1][1]);
      d[2] = offset_of(win[2][2], win[1][1]);
      d[3] = offset_of(win[2][0], win[1][1]);
      for (int i = 0; i < 3; i++) sum.c[i] = 0;
      for (int k = 0; k < 4; k++) begin
         a = d[k];
         b = d[(k + 1) % 4];
         cp.c[0] = a.c[1] * b.c[2] - a.c[2] * b.c[1];
         cp.c[1] = a.c[2] * b.c[0] - a.c[0] * b.c[2];
         cp.c[2] = a.c[0] * b.c[1] - a.c[1] * b.c[0];
         u = to_unit(cp);
         for (int i = 0; i < 3; i++) sum.c[i] += u.c[i];
      end
      nrm = to_unit(sum);
      for (int i = 0; i < 3; i++) lt.c[i] = light_q[i];
      lu = to_unit(lt);
      dotv = nrm.c[0] * lu.c[0] + nrm.c[1] * lu.c[1] + nrm.c[2] * lu.c[2];
      mag = dotv < 0 ? -dotv : dotv;
      sh = (mag * 255) >> 30;
      return sh > 255 ? 8'd255 : sh[7:0];
   endfunction

   // Advance the raster state by one accepted vertex
   task automatic absorb_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                logic [15:0] vz);
      int unsigned w, h, c, r;
      point_t nv;
      shade_t e;
      w = frame_width_q;
      h = frame_height_q;
      c = col_cnt;
      r = row_cnt;
      if (w < 3) w = 3;
      if (w > LINE_MAX) w = LINE_MAX;
      if (h < 3) h = 3;
      if (h > 1024) h = 1024;
      if (c >= LINE_MAX) c = 0;
      nv.x = vx;
      nv.y = vy;
      nv.z = vz;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = upper_buf[c];
      win[1][2] = middle_buf[c];
      win[2][2] = nv;
      upper_buf[c] = middle_buf[c];
      middle_buf[c] = nv;
      if (c >= 2 && r >= 2) begin
         e.shade = window_shade();
         e.column = 10'(c - 1);
         e.row = 10'(r - 1);
         shades_due.push_back(e);
      end
      if (c + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (!gaps_on || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Offer one vertex request and wait for it to be taken
   task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                              logic [15:0] vz);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= vx;
      req_vertex_y <= vy;
      req_vertex_z <= vz;
      do @(posedge clock); while (!req_ready);
      absorb_vertex(vx, vy, vz);
   endtask

   task automatic csr_write(logic [4:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (addr)
         REG_WIDTH:   frame_width_q = data[10:0];
         REG_HEIGHT:  frame_height_q = data[10:0];
         REG_LIGHT_X: light_q[0] = data[15:0];
         REG_LIGHT_Y: light_q[1] = data[15:0];
         REG_LIGHT_Z: light_q[2] = data[15:0];
         default: ;
      endcase
   endtask

   task automatic set_light(int lx, int ly, int lz);
      csr_write(REG_LIGHT_X, 32'(lx));
      csr_write(REG_LIGHT_Y, 32'(ly));
      csr_write(REG_LIGHT_Z, 32'(lz));
   endtask

   // Let the block go idle before touching registers
   task automatic drain();
      req_valid <= 1'b0;
      while (shades_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] clip16s(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return 16'(v);
   endfunction

   function automatic logic [15:0] clip16u(longint v);
      if (v > 65535) return 16'hffff;
      if (v < 0) return 16'h0000;
      return 16'(v);
   endfunction

   // Full rows wider than any row a later test sends, so every line buffer entry in use gets written
   task automatic test_wide_frame();
      csr_write(REG_WIDTH, 32'(WIDE_COLUMNS));
      csr_write(REG_HEIGHT, 32'd3);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < WIDE_COLUMNS; c++) begin
            if (r == 1 && (c % 8) != 5)
               send_vertex(16'($urandom), 16'($urandom), 16'd0);
            else
               send_vertex(clip16s(c * 4 - 2048), clip16s(r * 4),
                           16'(1000 + $urandom_range(0, 50)));
         end
      end
      drain();
   endtask

   // Small frames: plane, no depth at the centre, field extremes, identical neighbours, zero light
   task automatic test_directed();
      csr_write(REG_WIDTH, 32'd3);
      csr_write(REG_HEIGHT, 32'd3);
      set_light(0, 0, 32767);
      for (int i = 0; i < 9; i++)
         send_vertex(16'((i % 3) * 10), 16'((i / 3) * 10), 16'd1000);
      for (int i = 0; i < 9; i++)
         send_vertex(16'((i % 3) * 10), 16'((i / 3) * 10), i == 4 ? 16'd0 : 16'd500);
      // opposite corners at the rails, centre with full depth
      for (int i = 0; i < 9; i++)
         send_vertex(i % 2 ? 16'h8000 : 16'h7fff, i < 4 ? 16'h8000 : 16'h7fff,
                     i == 4 ? 16'hffff : (i % 3 == 0 ? 16'h0000 : 16'hffff));
      // identical neighbours give zero cross products
      for (int i = 0; i < 9; i++)
         send_vertex(16'sd7, 16'sd7, 16'd300);
      drain();
      set_light(0, 0, 0);
      for (int i = 0; i < 9; i++)
         send_vertex(16'((i % 3) * 9), 16'(i * 3), 16'(200 + i * 37));
      drain();
   endtask

   // Out-of-range sizes clamp, and extreme light directions
   task automatic test_register_extremes();
      csr_write(REG_WIDTH, 32'd0);
      csr_write(REG_HEIGHT, 32'd2047);
      set_light(-32768, 32767, -32768);
      for (int i = 0; i < 18; i++)
         send_vertex(16'($urandom_range(0, 200)), 16'(i * 20), 16'($urandom_range(1, 3000)));
      drain();
      csr_write(REG_WIDTH, 32'd2047);
      csr_write(REG_HEIGHT, 32'd1024);
      set_light(32767, -32768, 1);
      for (int i = 0; i < 12; i++)
         send_vertex(16'(i * 3), 16'sd5, 16'($urandom_range(1, 3000)));
      drain();
      csr_write(REG_WIDTH, 32'd4);
      csr_write(REG_HEIGHT, 32'd0);
      for (int i = 0; i < 24; i++)
         send_vertex(16'((i % 4) * 15), 16'((i / 4) * 15), 16'(800 + (i % 5) * 40));
      drain();
   endtask

   // Smooth random surfaces at random sizes and lights, with some noise vertices
   task automatic test_random_surfaces();
      int sent, w, h, kx, ky, base, noise;
      bit rough;
      sent = 0;
      ready_random = 1'b1;
      while (sent < 440) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(3, 8);
         h = $urandom_range(3, 6);
         csr_write(REG_WIDTH, 32'(w));
         csr_write(REG_HEIGHT, 32'(h));
         set_light($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                   $urandom_range(0, 65535) - 32768);
         kx = $urandom_range(0, 400) - 200;
         ky = $urandom_range(0, 400) - 200;
         base = $urandom_range(200, 60000);
         noise = $urandom_range(0, 40);
         rough = $urandom_range(0, 4) == 0;
         for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
               if (rough || $urandom_range(0, 19) == 0)
                  send_vertex(16'($urandom), 16'($urandom),
                              $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom));
               else
                  send_vertex(clip16s(c * 30 - 100 + $urandom_range(0, noise)),
                              clip16s(r * 30 - 100 + $urandom_range(0, noise)),
                              clip16u(base + kx * c + ky * r + $urandom_range(0, noise)));
               sent++;
            end
         end
         gaps_on = $urandom_range(0, 3) != 0;
         drain();
      end
      gaps_on = 1'b1;
   endtask

   // Long receiver hold while requests keep coming
   task automatic test_backpressure();
      csr_write(REG_WIDTH, 32'd5);
      csr_write(REG_HEIGHT, 32'd4);
      hold_req = 1'b1;
      gaps_on = 1'b0;
      for (int i = 0; i < 40; i++)
         send_vertex(16'((i % 5) * 25), 16'((i / 5) * 25), 16'(1500 + (i % 7) * 90));
      gaps_on = 1'b1;
      drain();
   endtask

   // Receiver readiness: free running, random stalls, or a long hold
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req <= 1'b0;
         hold_left <= 3000;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!ready_random) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case ($urandom_range(0, 99)) inside
            [0:69]: rsp_ready <= 1'b1;
            [70:95]: rsp_ready <= 1'b0;
            default: begin
               stall_left <= $urandom_range(10, 80);
               rsp_ready <= 1'b0;
            end
         endcase
      end
   end

   task automatic report(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   // Compare each response with the oldest predicted shade
   always @(posedge clock) begin
      shade_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (shades_due.size() == 0) begin
            report("unexpected response col", rsp_centre_column, -1);
         end else begin
            e = shades_due.pop_front();
            if (rsp_shade !== e.shade) report("shade", rsp_shade, e.shade);
            if (rsp_centre_column !== e.column) report("column", rsp_centre_column, e.column);
            if (rsp_centre_row !== e.row) report("row", rsp_centre_row, e.row);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      foreach (upper_buf[i]) begin
         upper_buf[i] = '{0, 0, 0};
         middle_buf[i] = '{0, 0, 0};
      end
      foreach (win[i, j]) win[i][j] = '{0, 0, 0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_wide_frame();
      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random_surfaces();
      if (shades_due.size() != 0) report("leftover shades", shades_due.size(), 0);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
